>>> sv/iht_pkg.sv
package iht_pkg;

  typedef enum logic [1:0] {
    ST_ADDED   = 2'd0,
    ST_PRESENT = 2'd1,
    ST_STORE   = 2'd2,
    ST_POOL    = 2'd3
  } status_t;

  localparam logic [7:0] TERMINATOR = 8'd0;

  // Widest bucket index that any supported bucket count needs.
  localparam int BUCKET_BITS_MAX = 12;

  // One identifier waiting between the front and the back.
  typedef struct packed {
    logic                       overflow;
    logic [BUCKET_BITS_MAX-1:0] bucket;
  } job_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_HEAD,
    BK_ENTRY,
    BK_LOAD,
    BK_RD_A,
    BK_RD_B,
    BK_CMP,
    BK_RESULT
  } back_state_t;

endpackage

>>> sv/iht_if.sv
interface iht_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       last;
  modport source (output valid, ch, last, input ready);
  modport sink   (input valid, ch, last, output ready);
endinterface

interface iht_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [9:0] start_index;
  logic [5:0] bucket;
  modport source (output valid, status, start_index, bucket, input ready);
  modport sink   (input valid, status, start_index, bucket, output ready);
endinterface

>>> sv/identifier_intern_hash_table_core.sv
// Identifier intern table. Input words carry one character and a last
// mark; an output word (status, start index, bucket) follows each last
// character. Characters are taken one per cycle, while no identifier is
// pending, into the string store by the front part, which keeps the
// running sum already reduced modulo the bucket count. At a last
// character the front queues the identifier in a one-slot queue and the
// back part walks the bucket chain, comparing text byte by byte (read
// entry byte, read candidate byte, compare) through the single store
// read port. A store overflow skips the chain walk and goes straight to
// the result. The front holds off new characters from the last
// character until the result has moved into the output register, so the
// next character can be taken in the cycle after that.
// Reset empties all buckets and the pool at once; store contents need no
// clearing. A stalled receiver holds the result and the back part, and
// then the front.
module identifier_intern_hash_table_core
  import iht_pkg::*;
#(
  parameter int STORE_BYTES = 1024,
  parameter int BUCKETS     = 64,
  parameter int ENTRIES     = 256
) (
  input  logic clk,
  input  logic rst,
  iht_in_if.sink    in_ch,
  iht_out_if.source out_res
);
  localparam int AW = $clog2(STORE_BYTES);
  localparam int PW = $clog2(STORE_BYTES + 1);
  localparam int EW = $clog2(ENTRIES + 1);
  localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam logic [BW:0] BUCKETS_W = (BW+1)'(BUCKETS);

  // Residue of one byte modulo the bucket count, a constant table.
  function automatic logic [BW-1:0] ch_residue(logic [7:0] c);
    logic [BW-1:0] r;
    r = '0;
    for (int i = 0; i < 256; i++)
      if (c == 8'(i)) r = BW'(i % BUCKETS);
    return r;
  endfunction

  function automatic logic [BW-1:0] add_mod(logic [BW-1:0] r, logic [7:0] c);
    logic [BW:0] t;
    t = {1'b0, r} + {1'b0, ch_residue(c)};
    if (t >= BUCKETS_W) t = t - BUCKETS_W;
    return t[BW-1:0];
  endfunction

  logic [7:0]    mem [STORE_BYTES];
  logic [PW-1:0] commit, wptr;
  logic [PW-1:0] commit_next, wptr_next;
  logic [BW-1:0] sum, sum_next, sum_in;
  logic          ovf, ovf_next;
  logic          busy, busy_next;  // one identifier queued or in the back
  job_t          job;
  logic          job_take, done, keep, rd_en;
  logic [1:0]    rs;
  logic [9:0]    rst_i;
  logic [5:0]    rb;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;
  logic          room;
  logic          jv, jv_next;
  logic          term_wr;
  logic [AW-1:0] term_addr;

  logic acc, full, term_full;
  assign in_ch.ready = !busy;
  assign acc  = in_ch.valid && in_ch.ready;
  assign full = (wptr >= PW'(STORE_BYTES));
  assign term_full = (wptr + (full ? 1'b0 : 1'b1)) >= PW'(STORE_BYTES);
  assign sum_in = full ? sum : add_mod(sum, in_ch.ch);

  // The terminator goes in the cycle after the last character; the input
  // is held off then, so the store needs a single write port.
  always_ff @(posedge clk) begin
    if (term_wr) mem[term_addr] <= TERMINATOR;
    else if (acc && !full) mem[AW'(wptr)] <= in_ch.ch;
    if (rd_en) rd_data <= mem[rd_addr];
  end

  always_comb begin
    commit_next = commit;
    wptr_next   = wptr;
    sum_next    = sum;
    ovf_next    = ovf;
    busy_next   = busy;
    jv_next     = jv;
    if (acc) begin
      if (in_ch.last) begin
        if (!full && !term_full) wptr_next = wptr + PW'(2);
        else if (!full) wptr_next = wptr + 1'b1;
        sum_next  = '0;
        ovf_next  = 1'b0;
        busy_next = 1'b1;
        jv_next   = 1'b1;
      end else if (!full) begin
        wptr_next = wptr + 1'b1;
        sum_next  = sum_in;
      end else begin
        ovf_next = 1'b1;
      end
    end
    if (job_take) jv_next = 1'b0;
    if (done) begin
      busy_next = 1'b0;
      if (keep) commit_next = wptr;
      else wptr_next = commit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      commit <= '0; wptr <= '0; sum <= '0; ovf <= 1'b0; busy <= 1'b0; jv <= 1'b0;
      term_wr <= 1'b0;
    end else begin
      commit  <= commit_next;
      wptr    <= wptr_next;
      sum     <= sum_next;
      ovf     <= ovf_next;
      busy    <= busy_next;
      jv      <= jv_next;
      term_wr <= acc && in_ch.last && !full && !term_full;
    end
  end

  always_ff @(posedge clk) begin
    term_addr <= AW'(wptr + 1'b1);
    if (acc && in_ch.last) begin
      job.bucket   <= BUCKET_BITS_MAX'(sum_in);
      job.overflow <= ovf || full || term_full;
    end
  end

  iht_back #(.STORE_BYTES(STORE_BYTES), .BUCKETS(BUCKETS), .ENTRIES(ENTRIES),
    .AW(AW), .PW(PW), .EW(EW), .BW(BW)) u_back (
    .clk, .rst, .job_valid(jv), .job, .job_take, .commit, .done, .keep,
    .res_status(rs), .res_start(rst_i), .res_bucket(rb), .rd_addr, .rd_data, .rd_en,
    .res_room(room));

  // Output register.
  assign room = !out_res.valid || out_res.ready;
  always_ff @(posedge clk) begin
    if (rst) out_res.valid <= 1'b0;
    else if (done) out_res.valid <= 1'b1;
    else if (out_res.ready) out_res.valid <= 1'b0;
    if (done) begin
      out_res.status <= rs; out_res.start_index <= rst_i; out_res.bucket <= rb;
    end
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !in_ch.ready) else $error("accept while busy");
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy) else $error("result without job");
  a_commit_le: assert property (@(posedge clk) disable iff (rst)
    !busy |-> commit <= wptr) else $error("pointer order");
endmodule

>>> sv/iht_back.sv
module iht_back
  import iht_pkg::*;
#(
  parameter int STORE_BYTES = 1024,
  parameter int BUCKETS     = 64,
  parameter int ENTRIES     = 256,
  parameter int AW          = 10,
  parameter int PW          = 11,
  parameter int EW          = 9,
  parameter int BW          = 6
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          job_valid,
  input  job_t          job,
  output logic          job_take,
  input  logic [PW-1:0] commit,
  output logic          done,
  output logic          keep,
  output logic [1:0]    res_status,
  output logic [9:0]    res_start,
  output logic [5:0]    res_bucket,
  output logic [AW-1:0] rd_addr,
  input  logic [7:0]    rd_data,
  output logic          rd_en,
  input  logic          res_room
);
  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [EW-1:0] NONE = EW'(ENTRIES);

  // Chain walk state.
  back_state_t state, state_next;
  logic [BW-1:0] bkt;
  logic [EW-1:0] head_q;     // chain head of the bucket being resolved
  logic [EW-1:0] cur;
  logic [PW-1:0] ea, eb;     // text under compare: entry and candidate
  logic [PW-1:0] est;
  logic [7:0]    xa;
  logic [EW-1:0] steps;
  logic [EW-1:0] count;
  status_t       rstat;
  logic [PW-1:0] rstart;

  logic [EW-1:0] heads [BUCKETS];
  logic [BUCKETS-1:0] hvalid;
  logic [PW-1:0] estart [ENTRIES];
  logic [EW-1:0] enext  [ENTRIES];
  logic [PW-1:0] estart_q;
  logic [EW-1:0] enext_q;

  logic [BW-1:0] job_bkt;
  logic chain_end, pool_full, at_end, byte_diff, byte_term, add_entry;
  assign job_bkt   = BW'(job.bucket);
  assign chain_end = (cur >= NONE) || (steps >= NONE);
  assign pool_full = (count >= NONE);
  assign at_end    = (ea >= PW'(STORE_BYTES)) || (eb >= PW'(STORE_BYTES));
  assign byte_diff = (xa != rd_data);
  assign byte_term = (xa == TERMINATOR);
  assign add_entry = (state == BK_ENTRY) && chain_end && !pool_full;

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE:   if (job_valid) state_next = job.overflow ? BK_RESULT : BK_HEAD;
      BK_HEAD:   state_next = BK_ENTRY;
      BK_ENTRY:  state_next = chain_end ? BK_RESULT : BK_LOAD;
      BK_LOAD:   state_next = BK_RD_A;
      BK_RD_A:   state_next = at_end ? BK_ENTRY : BK_RD_B;
      BK_RD_B:   state_next = BK_CMP;
      BK_CMP: begin
        if (byte_diff) state_next = BK_ENTRY;
        else if (byte_term) state_next = BK_RESULT;
        else state_next = BK_RD_A;
      end
      BK_RESULT: if (res_room) state_next = BK_IDLE;
      default:   state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    job_take = 1'b0;
    rd_en    = 1'b0;
    rd_addr  = '0;
    done     = 1'b0;
    case (state)
      BK_IDLE:   job_take = job_valid;
      BK_RD_A: begin
        rd_en   = 1'b1;
        rd_addr = AW'(ea);
      end
      BK_RD_B: begin
        rd_en   = 1'b1;
        rd_addr = AW'(eb);
      end
      BK_RESULT: done = res_room;
      default: ;
    endcase
  end

  assign res_status = rstat;
  assign res_start  = 10'(rstart);
  assign res_bucket = 6'(bkt);
  assign keep = (rstat == ST_ADDED);

  // Table reads registered; the head is read once as the job is taken.
  always_ff @(posedge clk) begin
    estart_q <= estart[IW'(cur)];
    enext_q  <= enext[IW'(cur)];
    if (job_take) head_q <= hvalid[job_bkt] ? heads[job_bkt] : NONE;
  end

  // New entries are linked at the head of their chain.
  always_ff @(posedge clk) begin
    if (add_entry) begin
      estart[IW'(count)] <= commit;
      enext[IW'(count)]  <= head_q;
      heads[bkt]         <= count;
    end
  end

  // Compare runs one byte at a time: read a, read b, compare.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= BK_IDLE;
      hvalid <= '0;
      count  <= '0;
    end else begin
      state <= state_next;
      case (state)
        BK_IDLE: if (job_valid) begin
          steps  <= '0;
          rstat  <= ST_STORE;
          rstart <= '0;
          bkt    <= job.overflow ? '0 : job_bkt;
        end
        BK_HEAD: cur <= head_q;
        BK_ENTRY: if (chain_end) begin
          if (pool_full) begin
            rstat <= ST_POOL; rstart <= '0;
          end else begin
            rstat <= ST_ADDED; rstart <= commit;
            hvalid[bkt] <= 1'b1;
            count <= count + 1'b1;
          end
        end
        BK_LOAD: begin
          ea <= estart_q; est <= estart_q; eb <= commit;
        end
        BK_RD_A: if (at_end) begin
          cur <= enext_q; steps <= steps + 1'b1;
        end
        BK_RD_B: xa <= rd_data;
        BK_CMP: begin
          if (byte_diff) begin
            cur <= enext_q; steps <= steps + 1'b1;
          end else if (byte_term) begin
            rstat <= ST_PRESENT; rstart <= est;
          end else begin
            ea <= ea + 1'b1; eb <= eb + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end
endmodule
